// File: src/scc_pkg.sv
`timescale 1ns / 1ps

package scc_pkg;

    localparam int NODE_W        = 6;
    localparam int CFG_W         = 7;
    localparam int STATUS_W      = 2;
    localparam int ID_LIMIT      = 1 << NODE_W;
    localparam int MAX_NODES_DEF = 64;

    localparam logic [STATUS_W-1:0] ST_NODE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_EDGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_RUN = 1'b1;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE   = 5'd0;
    localparam logic [OP_W-1:0] OP_EDGE   = 5'd1;
    localparam logic [OP_W-1:0] OP_EMPTY  = 5'd2;
    localparam logic [OP_W-1:0] OP_START  = 5'd3;
    localparam logic [OP_W-1:0] OP_RSKIP  = 5'd4;
    localparam logic [OP_W-1:0] OP_RVISIT = 5'd5;
    localparam logic [OP_W-1:0] OP_ROWLD  = 5'd6;
    localparam logic [OP_W-1:0] OP_SSKIP  = 5'd7;
    localparam logic [OP_W-1:0] OP_SVISIT = 5'd8;
    localparam logic [OP_W-1:0] OP_SCHK   = 5'd9;
    localparam logic [OP_W-1:0] OP_UPD    = 5'd10;
    localparam logic [OP_W-1:0] OP_PSTART = 5'd11;
    localparam logic [OP_W-1:0] OP_POP    = 5'd12;
    localparam logic [OP_W-1:0] OP_POPW   = 5'd13;
    localparam logic [OP_W-1:0] OP_RET    = 5'd14;
    localparam logic [OP_W-1:0] OP_OSTART = 5'd15;
    localparam logic [OP_W-1:0] OP_USKIP  = 5'd16;
    localparam logic [OP_W-1:0] OP_PLACE  = 5'd17;
    localparam logic [OP_W-1:0] OP_ESKIP  = 5'd18;
    localparam logic [OP_W-1:0] OP_EMIT   = 5'd19;
    localparam logic [OP_W-1:0] OP_ENDC   = 5'd20;
    localparam logic [OP_W-1:0] OP_CLEAR  = 5'd21;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic in_run;
        logic n_zero;
        logic r_end;
        logic vis_r;
        logic nxt_end;
        logic row_bit;
        logic vis_t;
        logic onstk_t;
        logic low_eq;
        logic last;
        logic dp_zero;
        logic all_placed;
        logic placed_u;
        logic ready;
        logic e_end;
        logic em_bit;
    } sts_t;

endpackage

// File: src/scc_ctrl.sv
`timescale 1ns / 1ps

module scc_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  scc_pkg::sts_t sts,
    output scc_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROOT  = 4'd1;
    localparam logic [3:0] S_ROW   = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_UPD   = 4'd4;
    localparam logic [3:0] S_DONE  = 4'd5;
    localparam logic [3:0] S_POP   = 4'd6;
    localparam logic [3:0] S_POPW  = 4'd7;
    localparam logic [3:0] S_RET   = 4'd8;
    localparam logic [3:0] S_OSEL  = 4'd9;
    localparam logic [3:0] S_OWAIT = 4'd10;
    localparam logic [3:0] S_OCHK  = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;
    localparam logic [3:0] S_CLEAR = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = !((state_reg == S_IDLE) && sts.out_free);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = scc_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && sts.out_free)
                begin
                    if (sts.in_run)
                    begin
                        if (sts.n_zero)
                        begin
                            cmd.op = scc_pkg::OP_EMPTY;
                        end
                        else
                        begin
                            cmd.op     = scc_pkg::OP_START;
                            state_next = S_ROOT;
                        end
                    end
                    else
                    begin
                        cmd.op = scc_pkg::OP_EDGE;
                    end
                end
            end
            S_ROOT:
            begin
                if (sts.r_end)
                begin
                    cmd.op     = scc_pkg::OP_OSTART;
                    state_next = S_OSEL;
                end
                else if (sts.vis_r)
                begin
                    cmd.op = scc_pkg::OP_RSKIP;
                end
                else
                begin
                    cmd.op     = scc_pkg::OP_RVISIT;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                cmd.op     = scc_pkg::OP_ROWLD;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.nxt_end)
                begin
                    state_next = S_DONE;
                end
                else if (!sts.row_bit)
                begin
                    cmd.op = scc_pkg::OP_SSKIP;
                end
                else if (!sts.vis_t)
                begin
                    cmd.op     = scc_pkg::OP_SVISIT;
                    state_next = S_ROW;
                end
                else if (sts.onstk_t)
                begin
                    cmd.op     = scc_pkg::OP_SCHK;
                    state_next = S_UPD;
                end
                else
                begin
                    cmd.op = scc_pkg::OP_SSKIP;
                end
            end
            S_UPD:
            begin
                cmd.op     = scc_pkg::OP_UPD;
                state_next = S_SCAN;
            end
            S_DONE:
            begin
                if (sts.low_eq)
                begin
                    cmd.op     = scc_pkg::OP_PSTART;
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_RET;
                end
            end
            S_POP:
            begin
                cmd.op     = scc_pkg::OP_POP;
                state_next = S_POPW;
            end
            S_POPW:
            begin
                cmd.op     = scc_pkg::OP_POPW;
                state_next = sts.last ? S_RET : S_POP;
            end
            S_RET:
            begin
                if (sts.dp_zero)
                begin
                    cmd.op     = scc_pkg::OP_RSKIP;
                    state_next = S_ROOT;
                end
                else
                begin
                    cmd.op     = scc_pkg::OP_RET;
                    state_next = S_ROW;
                end
            end
            S_OSEL:
            begin
                if (sts.all_placed)
                begin
                    state_next = S_CLEAR;
                end
                else if (sts.placed_u)
                begin
                    cmd.op = scc_pkg::OP_USKIP;
                end
                else
                begin
                    state_next = S_OWAIT;
                end
            end
            S_OWAIT:
            begin
                state_next = S_OCHK;
            end
            S_OCHK:
            begin
                if (sts.ready)
                begin
                    cmd.op     = scc_pkg::OP_PLACE;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.op     = scc_pkg::OP_USKIP;
                    state_next = S_OSEL;
                end
            end
            S_EMIT:
            begin
                if (sts.e_end)
                begin
                    cmd.op     = scc_pkg::OP_ENDC;
                    state_next = S_OSEL;
                end
                else if (!sts.em_bit)
                begin
                    cmd.op = scc_pkg::OP_ESKIP;
                end
                else if (sts.out_free)
                begin
                    cmd.op = scc_pkg::OP_EMIT;
                end
            end
            S_CLEAR:
            begin
                cmd.op     = scc_pkg::OP_CLEAR;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/scc_dpath.sv
`timescale 1ns / 1ps

module scc_dpath
#(
    parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [scc_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic                             func,
    input  logic [scc_pkg::NODE_W-1:0]       source_node,
    input  logic [scc_pkg::NODE_W-1:0]       target_node,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [scc_pkg::STATUS_W-1:0]     status,
    output logic [scc_pkg::NODE_W-1:0]       node_id,
    output logic [scc_pkg::NODE_W-1:0]       component_index,
    output logic                             component_end,
    output logic                             run_end,
    input  scc_pkg::cmd_t                    cmd,
    output scc_pkg::sts_t                    sts
);

    localparam int CAP = (MAX_NODES < scc_pkg::ID_LIMIT) ? MAX_NODES : scc_pkg::ID_LIMIT;
    localparam int IW  = $clog2(CAP);
    localparam int CW  = IW + 1;

    typedef struct packed {
        logic [IW-1:0] node;
        logic [CW-1:0] next;
        logic [IW-1:0] low;
        logic [IW-1:0] vo;
    } frame_t;

    // memories
    logic [CAP-1:0] mat_mem [CAP];
    logic [IW-1:0]  vo_mem  [CAP];
    logic [IW-1:0]  ms_mem  [CAP];
    frame_t         ss_mem  [CAP];
    logic [IW-1:0]  raw_mem [CAP];
    logic [CAP-1:0] cs_mem  [CAP];
    logic [CAP-1:0] cm_mem  [CAP];

    logic [CAP-1:0] mat_rd_reg;
    logic           rv_rd_reg;
    logic [IW-1:0]  vo_rd_reg;
    logic [IW-1:0]  ms_rd_reg;
    frame_t         ss_rd_reg;
    logic [IW-1:0]  raw_rd_reg;
    logic [CAP-1:0] cs_rd_reg;
    logic [CAP-1:0] cm_rd_reg;

    logic [scc_pkg::CFG_W-1:0] ncfg_reg;
    logic [CW-1:0]  n_reg;
    logic [CW-1:0]  r_reg;
    logic [CW-1:0]  nxt_reg;
    logic [CW-1:0]  idx_reg;
    logic [CW-1:0]  sp_reg;
    logic [CW-1:0]  dp_reg;
    logic [CW-1:0]  ncomp_reg;
    logic [CW-1:0]  k_reg;
    logic [CW-1:0]  u_reg;
    logic [CW-1:0]  e_reg;
    logic [IW-1:0]  v_reg;
    logic [IW-1:0]  low_reg;
    logic [IW-1:0]  vo_reg;
    logic [CAP-1:0] row_reg;
    logic [CAP-1:0] rowv_reg;
    logic [CAP-1:0] visited_reg;
    logic [CAP-1:0] onstk_reg;
    logic [CAP-1:0] acc_s_reg;
    logic [CAP-1:0] acc_m_reg;
    logic [CAP-1:0] placed_reg;
    logic [CAP-1:0] em_reg;
    logic           last_reg;
    logic           lastc_reg;

    logic                        out_valid_reg;
    logic [scc_pkg::STATUS_W-1:0] status_reg;
    logic [scc_pkg::NODE_W-1:0]  node_reg;
    logic [scc_pkg::NODE_W-1:0]  comp_reg;
    logic                        cend_reg;
    logic                        rend_reg;

    logic [CW-1:0]  n_eff;
    logic           bad_edge;
    logic [IW-1:0]  src_i;
    logic [IW-1:0]  dst_i;
    logic [IW-1:0]  t_i;
    logic [IW-1:0]  vis_i;
    logic [IW-1:0]  mat_addr;
    logic [CAP-1:0] nmask;
    logic [CAP-1:0] row_in;
    logic [CAP-1:0] e_bit;
    logic           out_free;
    logic           out_load;
    frame_t         push_frame;

    assign n_eff    = (ncfg_reg > scc_pkg::CFG_W'(CAP)) ? CW'(CAP) : CW'(ncfg_reg);
    assign bad_edge = ({1'b0, source_node} >= scc_pkg::CFG_W'(n_eff)) ||
                      ({1'b0, target_node} >= scc_pkg::CFG_W'(n_eff));
    assign src_i    = IW'(source_node);
    assign dst_i    = IW'(target_node);
    assign t_i      = nxt_reg[IW-1:0];
    assign vis_i    = (cmd.op == scc_pkg::OP_SVISIT) ? t_i : r_reg[IW-1:0];
    assign row_in   = rv_rd_reg ? mat_rd_reg : '0;
    assign e_bit    = CAP'(1) << e_reg[IW-1:0];
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = ((cmd.op == scc_pkg::OP_EDGE) && bad_edge) ||
                      (cmd.op == scc_pkg::OP_EMPTY) || (cmd.op == scc_pkg::OP_EMIT);

    assign push_frame.node = v_reg;
    assign push_frame.next = nxt_reg + CW'(1);
    assign push_frame.low  = low_reg;
    assign push_frame.vo   = vo_reg;

    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            nmask[i] = (CW'(i) < n_reg);
        end
    end

    always_comb
    begin
        unique case (cmd.op)
            scc_pkg::OP_RVISIT: mat_addr = r_reg[IW-1:0];
            scc_pkg::OP_SVISIT: mat_addr = t_i;
            scc_pkg::OP_RET:    mat_addr = ss_rd_reg.node;
            scc_pkg::OP_POP:    mat_addr = ms_rd_reg;
            default:            mat_addr = '0;
        endcase
    end

    assign sts.out_free   = out_free;
    assign sts.in_run     = (func == scc_pkg::FUNC_RUN);
    assign sts.n_zero     = (n_eff == '0);
    assign sts.r_end      = (r_reg == n_reg);
    assign sts.vis_r      = visited_reg[r_reg[IW-1:0]];
    assign sts.nxt_end    = (nxt_reg == n_reg);
    assign sts.row_bit    = row_reg[t_i];
    assign sts.vis_t      = visited_reg[t_i];
    assign sts.onstk_t    = onstk_reg[t_i];
    assign sts.low_eq     = (low_reg == vo_reg);
    assign sts.last       = last_reg;
    assign sts.dp_zero    = (dp_reg == '0);
    assign sts.all_placed = (placed_reg == nmask);
    assign sts.placed_u   = placed_reg[u_reg[IW-1:0]];
    assign sts.ready      = ((cs_rd_reg & ~placed_reg) == '0);
    assign sts.e_end      = (e_reg == n_reg);
    assign sts.em_bit     = em_reg[e_reg[IW-1:0]];

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign node_id         = node_reg;
    assign component_index = comp_reg;
    assign component_end   = cend_reg;
    assign run_end         = rend_reg;

    // memory ports
    always_ff @(posedge clk)
    begin
        mat_rd_reg <= mat_mem[mat_addr];
        rv_rd_reg  <= rowv_reg[mat_addr];
        vo_rd_reg  <= vo_mem[t_i];
        ms_rd_reg  <= ms_mem[sp_reg[IW-1:0] - IW'(1)];
        ss_rd_reg  <= ss_mem[dp_reg[IW-1:0] - IW'(1)];
        raw_rd_reg <= raw_mem[u_reg[IW-1:0]];
        cs_rd_reg  <= cs_mem[raw_rd_reg];
        cm_rd_reg  <= cm_mem[raw_rd_reg];

        if (cmd.op == scc_pkg::OP_EDGE && !bad_edge)
        begin
            if (rowv_reg[src_i])
            begin
                mat_mem[src_i][dst_i] <= 1'b1;
            end
            else
            begin
                mat_mem[src_i] <= CAP'(1) << dst_i;
            end
        end
        if (cmd.op == scc_pkg::OP_RVISIT || cmd.op == scc_pkg::OP_SVISIT)
        begin
            vo_mem[vis_i]              <= idx_reg[IW-1:0];
            ms_mem[sp_reg[IW-1:0]]     <= vis_i;
        end
        if (cmd.op == scc_pkg::OP_SVISIT)
        begin
            ss_mem[dp_reg[IW-1:0]] <= push_frame;
        end
        if (cmd.op == scc_pkg::OP_POP)
        begin
            raw_mem[ms_rd_reg] <= ncomp_reg[IW-1:0];
        end
        if (cmd.op == scc_pkg::OP_POPW && last_reg)
        begin
            cs_mem[ncomp_reg[IW-1:0]] <= (acc_s_reg | row_in) & ~acc_m_reg & nmask;
            cm_mem[ncomp_reg[IW-1:0]] <= acc_m_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncfg_reg      <= '0;
            n_reg         <= '0;
            r_reg         <= '0;
            nxt_reg       <= '0;
            idx_reg       <= '0;
            sp_reg        <= '0;
            dp_reg        <= '0;
            ncomp_reg     <= '0;
            k_reg         <= '0;
            u_reg         <= '0;
            e_reg         <= '0;
            v_reg         <= '0;
            low_reg       <= '0;
            vo_reg        <= '0;
            row_reg       <= '0;
            rowv_reg      <= '0;
            visited_reg   <= '0;
            onstk_reg     <= '0;
            acc_s_reg     <= '0;
            acc_m_reg     <= '0;
            placed_reg    <= '0;
            em_reg        <= '0;
            last_reg      <= 1'b0;
            lastc_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            node_reg      <= '0;
            comp_reg      <= '0;
            cend_reg      <= 1'b0;
            rend_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ncfg_reg <= cfg_wr_data;
            end
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                scc_pkg::OP_EDGE:
                begin
                    if (bad_edge)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= scc_pkg::ST_BAD_EDGE;
                        node_reg      <= '0;
                        comp_reg      <= '0;
                        cend_reg      <= 1'b0;
                        rend_reg      <= 1'b0;
                    end
                    else
                    begin
                        rowv_reg[src_i] <= 1'b1;
                    end
                end
                scc_pkg::OP_EMPTY:
                begin
                    out_valid_reg <= 1'b1;
                    status_reg    <= scc_pkg::ST_EMPTY;
                    node_reg      <= '0;
                    comp_reg      <= '0;
                    cend_reg      <= 1'b0;
                    rend_reg      <= 1'b1;
                    rowv_reg      <= '0;
                end
                scc_pkg::OP_START:
                begin
                    n_reg       <= n_eff;
                    visited_reg <= '0;
                    onstk_reg   <= '0;
                    r_reg       <= '0;
                    idx_reg     <= '0;
                    sp_reg      <= '0;
                    dp_reg      <= '0;
                    ncomp_reg   <= '0;
                end
                scc_pkg::OP_RSKIP:
                begin
                    r_reg <= r_reg + CW'(1);
                end
                scc_pkg::OP_RVISIT, scc_pkg::OP_SVISIT:
                begin
                    if (cmd.op == scc_pkg::OP_SVISIT)
                    begin
                        dp_reg <= dp_reg + CW'(1);
                    end
                    visited_reg[vis_i] <= 1'b1;
                    onstk_reg[vis_i]   <= 1'b1;
                    v_reg              <= vis_i;
                    vo_reg             <= idx_reg[IW-1:0];
                    low_reg            <= idx_reg[IW-1:0];
                    idx_reg            <= idx_reg + CW'(1);
                    sp_reg             <= sp_reg + CW'(1);
                    nxt_reg            <= '0;
                end
                scc_pkg::OP_ROWLD:
                begin
                    row_reg <= row_in;
                end
                scc_pkg::OP_SSKIP, scc_pkg::OP_SCHK:
                begin
                    nxt_reg <= nxt_reg + CW'(1);
                end
                scc_pkg::OP_UPD:
                begin
                    if (vo_rd_reg < low_reg)
                    begin
                        low_reg <= vo_rd_reg;
                    end
                end
                scc_pkg::OP_PSTART:
                begin
                    acc_s_reg <= '0;
                    acc_m_reg <= '0;
                end
                scc_pkg::OP_POP:
                begin
                    onstk_reg[ms_rd_reg] <= 1'b0;
                    acc_m_reg[ms_rd_reg] <= 1'b1;
                    sp_reg               <= sp_reg - CW'(1);
                    last_reg             <= (ms_rd_reg == v_reg);
                end
                scc_pkg::OP_POPW:
                begin
                    acc_s_reg <= acc_s_reg | row_in;
                    if (last_reg)
                    begin
                        ncomp_reg <= ncomp_reg + CW'(1);
                    end
                end
                scc_pkg::OP_RET:
                begin
                    v_reg   <= ss_rd_reg.node;
                    nxt_reg <= ss_rd_reg.next;
                    vo_reg  <= ss_rd_reg.vo;
                    low_reg <= (low_reg < ss_rd_reg.low) ? low_reg : ss_rd_reg.low;
                    dp_reg  <= dp_reg - CW'(1);
                end
                scc_pkg::OP_OSTART:
                begin
                    placed_reg <= '0;
                    k_reg      <= '0;
                    u_reg      <= '0;
                end
                scc_pkg::OP_USKIP:
                begin
                    u_reg <= u_reg + CW'(1);
                end
                scc_pkg::OP_PLACE:
                begin
                    em_reg     <= cm_rd_reg;
                    lastc_reg  <= ((placed_reg | cm_rd_reg) == nmask);
                    placed_reg <= placed_reg | cm_rd_reg;
                    e_reg      <= '0;
                end
                scc_pkg::OP_ESKIP:
                begin
                    e_reg <= e_reg + CW'(1);
                end
                scc_pkg::OP_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    status_reg    <= scc_pkg::ST_NODE;
                    node_reg      <= scc_pkg::NODE_W'(e_reg[IW-1:0]);
                    comp_reg      <= scc_pkg::NODE_W'(k_reg);
                    cend_reg      <= ((em_reg & ~e_bit) == '0);
                    rend_reg      <= ((em_reg & ~e_bit) == '0) && lastc_reg;
                    em_reg        <= em_reg & ~e_bit;
                    e_reg         <= e_reg + CW'(1);
                end
                scc_pkg::OP_ENDC:
                begin
                    k_reg <= k_reg + CW'(1);
                    u_reg <= '0;
                end
                scc_pkg::OP_CLEAR:
                begin
                    rowv_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: src/scc_condensation_order.sv
`timescale 1ns / 1ps
// Edge load: one transaction per cycle while the output register is free; a bad edge
// result shows the next cycle. Run: search walks each visited row one matrix bit per cycle,
// pausing for row loads and low-link updates, then ordering rescans nodes per component,
// and emission waits on output stalls. One run at a time; row scan and ordering set its length.
// Reset: async, active low; control clears and every matrix row reads as empty through
// per-row valid flags, so no clearing pass is needed.

module scc_condensation_order
#(
    parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [scc_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [scc_pkg::NODE_W-1:0]    source_node,
    input  logic [scc_pkg::NODE_W-1:0]    target_node,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [scc_pkg::STATUS_W-1:0]  status,
    output logic [scc_pkg::NODE_W-1:0]    node_id,
    output logic [scc_pkg::NODE_W-1:0]    component_index,
    output logic                          component_end,
    output logic                          run_end
);

    scc_pkg::cmd_t cmd;
    scc_pkg::sts_t sts;

    scc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    scc_dpath #(.MAX_NODES(MAX_NODES)) u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .func            (func),
        .source_node     (source_node),
        .target_node     (target_node),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .node_id         (node_id),
        .component_index (component_index),
        .component_end   (component_end),
        .run_end         (run_end),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic [scc_pkg::STATUS_W-1:0] status;
        logic [scc_pkg::NODE_W-1:0]   node_id;
        logic [scc_pkg::NODE_W-1:0]   comp;
        logic                         comp_end;
        logic                         last_of_run;
    } node_report_t;

    typedef struct {
        int           count;
        logic         op;
        int           src;
        int           dst;
        bit           fixed;
        node_report_t want;
    } edge_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [scc_pkg::CFG_W-1:0]    cfg_wr_data;
    logic                         in_valid;
    logic                         in_stall;
    logic                         func;
    logic [scc_pkg::NODE_W-1:0]   source_node;
    logic [scc_pkg::NODE_W-1:0]   target_node;
    logic                         out_valid;
    logic                         out_stall;
    logic [scc_pkg::STATUS_W-1:0] status;
    logic [scc_pkg::NODE_W-1:0]   node_id;
    logic [scc_pkg::NODE_W-1:0]   component_index;
    logic                         component_end;
    logic                         run_end;

    scc_condensation_order dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .source_node     (source_node),
        .target_node     (target_node),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .node_id         (node_id),
        .component_index (component_index),
        .component_end   (component_end),
        .run_end         (run_end)
    );

    // predictor state
    bit [63:0]    adj [64];
    int           node_count_reg;
    node_report_t pending_reports [$];

    int  mismatches;
    int  items_sent;
    int  runs_sent;
    int  reports_seen;
    int  idle_cycles;
    bit  quiet;
    bit  flood_req;
    bit  flood_done;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void queue_report(input node_report_t rep);
        pending_reports = {pending_reports, rep};
    endfunction

    function automatic void drop_last_report();
        pending_reports.delete(pending_reports.size() - 1);
    endfunction

    function automatic int draw_gap();
        if ($urandom_range(0, 99) < 4)
        begin
            quiet = ~quiet;
        end
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    // Tarjan search, dependency-first ordering, emission, then matrix clear.
    function automatic void predict_components(input logic op, input int src, input int dst);
        int  n;
        int  vo [64];
        int  ll [64];
        int  mstk [64];
        int  fnode [64];
        int  fnext [64];
        int  rc [64];
        bit  vis [64];
        bit  ons [64];
        bit  cedge [64][64];
        int  cmin [64];
        int  pend [64];
        int  fidx [64];
        bit  placed [64];
        int  next_idx, sp, dp, ncomp, v, t, m, p, c, d, best, last, cnt;
        node_report_t rep;

        n = (node_count_reg > 64) ? 64 : node_count_reg;
        if (op == scc_pkg::FUNC_ADD)
        begin
            if (src >= n || dst >= n)
            begin
                rep = '{scc_pkg::ST_BAD_EDGE, '0, '0, 1'b0, 1'b0};
                queue_report(rep);
            end
            else
            begin
                adj[src][dst] = 1'b1;
            end
            return;
        end
        if (n == 0)
        begin
            rep = '{scc_pkg::ST_EMPTY, '0, '0, 1'b0, 1'b1};
            queue_report(rep);
            foreach (adj[i]) adj[i] = '0;
            return;
        end
        next_idx = 0;
        sp = 0;
        dp = 0;
        ncomp = 0;
        for (int i = 0; i < 64; i++)
        begin
            vis[i] = 0;
            ons[i] = 0;
        end
        for (int r = 0; r < n; r++)
        begin
            if (vis[r]) continue;
            vis[r] = 1;
            vo[r] = next_idx;
            ll[r] = next_idx;
            next_idx++;
            mstk[sp] = r;
            sp++;
            ons[r] = 1;
            fnode[dp] = r;
            fnext[dp] = 0;
            dp++;
            while (dp > 0)
            begin
                v = fnode[dp-1];
                while (fnext[dp-1] < n && !adj[v][fnext[dp-1]]) fnext[dp-1]++;
                if (fnext[dp-1] < n)
                begin
                    t = fnext[dp-1];
                    fnext[dp-1]++;
                    if (!vis[t])
                    begin
                        vis[t] = 1;
                        vo[t] = next_idx;
                        ll[t] = next_idx;
                        next_idx++;
                        mstk[sp] = t;
                        sp++;
                        ons[t] = 1;
                        fnode[dp] = t;
                        fnext[dp] = 0;
                        dp++;
                    end
                    else if (ons[t] && vo[t] < ll[v])
                    begin
                        ll[v] = vo[t];
                    end
                    continue;
                end
                dp--;
                if (ll[v] == vo[v])
                begin
                    while (sp > 0)
                    begin
                        sp--;
                        m = mstk[sp];
                        ons[m] = 0;
                        rc[m] = ncomp;
                        if (m == v) break;
                    end
                    ncomp++;
                end
                if (dp > 0)
                begin
                    p = fnode[dp-1];
                    if (ll[v] < ll[p]) ll[p] = ll[v];
                end
            end
        end
        for (int i = 0; i < 64; i++)
        begin
            placed[i] = 0;
            cmin[i] = 255;
            for (int j = 0; j < 64; j++) cedge[i][j] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            c = rc[i];
            if (cmin[c] == 255) cmin[c] = i;
            for (int j = 0; j < n; j++)
            begin
                d = rc[j];
                if (adj[i][j] && c != d) cedge[c][d] = 1;
            end
        end
        for (int i = 0; i < ncomp; i++)
        begin
            pend[i] = 0;
            for (int j = 0; j < ncomp; j++) pend[i] += cedge[i][j];
        end
        for (int k = 0; k < ncomp; k++)
        begin
            best = ncomp;
            for (int i = 0; i < ncomp; i++)
            begin
                if (!placed[i] && pend[i] == 0 && (best == ncomp || cmin[i] < cmin[best]))
                    best = i;
            end
            if (best == ncomp) break;
            placed[best] = 1;
            fidx[best] = k;
            for (int i = 0; i < ncomp; i++)
            begin
                if (cedge[i][best] && pend[i] > 0) pend[i]--;
            end
        end
        cnt = 0;
        for (int k = 0; k < ncomp; k++)
        begin
            last = -1;
            for (int u = 0; u < n; u++)
            begin
                if (placed[rc[u]] && fidx[rc[u]] == k)
                begin
                    rep = '{scc_pkg::ST_NODE, scc_pkg::NODE_W'(u), scc_pkg::NODE_W'(k),
                            1'b0, 1'b0};
                    queue_report(rep);
                    last = pending_reports.size() - 1;
                    cnt++;
                end
            end
            if (last >= 0) pending_reports[last].comp_end = 1'b1;
        end
        if (cnt > 0) pending_reports[pending_reports.size()-1].last_of_run = 1'b1;
        foreach (adj[i]) adj[i] = '0;
    endfunction

    // Called at a rising edge; leaves at the edge where the transaction is taken.
    task automatic send_item(input logic op, input int src, input int dst, input int gap,
                             input bit fixed, input node_report_t want);
        int sz;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= op;
        source_node <= scc_pkg::NODE_W'(src);
        target_node <= scc_pkg::NODE_W'(dst);
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        sz = pending_reports.size();
        predict_components(op, src, dst);
        if (fixed)
        begin
            while (pending_reports.size() > sz) drop_last_report();
            queue_report(want);
        end
        items_sent++;
        if (op == scc_pkg::FUNC_RUN) runs_sent++;
    endtask

    task automatic drain_and_set(input int count);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0) @(posedge clk);
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= scc_pkg::CFG_W'(count);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        node_count_reg = count;
    endtask

    edge_row_t directed_rows [24] = '{
        '{0,   scc_pkg::FUNC_RUN, 0,  0,  1, '{scc_pkg::ST_EMPTY,    6'd0, 6'd0, 1'b0, 1'b1}},
        '{0,   scc_pkg::FUNC_ADD, 0,  0,  1, '{scc_pkg::ST_BAD_EDGE, 6'd0, 6'd0, 1'b0, 1'b0}},
        '{1,   scc_pkg::FUNC_ADD, 0,  0,  0, '0},
        '{1,   scc_pkg::FUNC_RUN, 0,  0,  1, '{scc_pkg::ST_NODE,     6'd0, 6'd0, 1'b1, 1'b1}},
        '{64,  scc_pkg::FUNC_ADD, 63, 63, 0, '0},
        '{64,  scc_pkg::FUNC_ADD, 63, 0,  0, '0},
        '{64,  scc_pkg::FUNC_ADD, 0,  63, 0, '0},
        '{64,  scc_pkg::FUNC_ADD, 42, 21, 0, '0},
        '{64,  scc_pkg::FUNC_RUN, 0,  0,  0, '0},
        '{127, scc_pkg::FUNC_ADD, 63, 62, 0, '0},
        '{127, scc_pkg::FUNC_ADD, 21, 42, 0, '0},
        '{127, scc_pkg::FUNC_RUN, 0,  0,  0, '0},
        '{5,   scc_pkg::FUNC_ADD, 5,  0,  1, '{scc_pkg::ST_BAD_EDGE, 6'd0, 6'd0, 1'b0, 1'b0}},
        '{5,   scc_pkg::FUNC_ADD, 0,  63, 1, '{scc_pkg::ST_BAD_EDGE, 6'd0, 6'd0, 1'b0, 1'b0}},
        '{5,   scc_pkg::FUNC_ADD, 1,  2,  0, '0},
        '{5,   scc_pkg::FUNC_ADD, 1,  2,  0, '0},
        '{5,   scc_pkg::FUNC_ADD, 2,  1,  0, '0},
        '{5,   scc_pkg::FUNC_ADD, 3,  4,  0, '0},
        '{5,   scc_pkg::FUNC_RUN, 0,  0,  0, '0},
        '{8,   scc_pkg::FUNC_ADD, 7,  0,  0, '0},
        '{8,   scc_pkg::FUNC_ADD, 0,  7,  0, '0},
        '{8,   scc_pkg::FUNC_ADD, 1,  0,  0, '0},
        '{4,   scc_pkg::FUNC_RUN, 0,  0,  0, '0},
        '{8,   scc_pkg::FUNC_RUN, 0,  0,  0, '0}
    };

    // stimulus
    initial
    begin
        int n;
        int k;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        func        = scc_pkg::FUNC_ADD;
        source_node = '0;
        target_node = '0;
        flood_req   = 0;
        node_count_reg = 0;
        foreach (adj[i]) adj[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].count != node_count_reg || r == 0)
                drain_and_set(directed_rows[r].count);
            send_item(directed_rows[r].op, directed_rows[r].src, directed_rows[r].dst,
                      draw_gap(), directed_rows[r].fixed, directed_rows[r].want);
        end

        // back-pressure: receiver holds off while bad edges pour in
        drain_and_set(2);
        flood_req = 1;
        for (int i = 0; i < 40; i++)
            send_item(scc_pkg::FUNC_ADD, 63 - (i % 8), i, 0, 1'b0, '0);
        send_item(scc_pkg::FUNC_RUN, 0, 0, 0, 1'b0, '0);

        while (items_sent < 350)
        begin
            k = $urandom_range(0, 19);
            if (k == 0)      n = 0;
            else if (k == 1) n = 64;
            else if (k == 2) n = $urandom_range(65, 127);
            else             n = $urandom_range(2, 12);
            drain_and_set(n);
            if (n > 64) n = 64;
            k = (n == 0) ? $urandom_range(0, 3) : $urandom_range(1, (n > 12) ? 40 : 3 * n);
            for (int i = 0; i < k; i++)
            begin
                if (n > 0 && $urandom_range(0, 9) != 0)
                    send_item(scc_pkg::FUNC_ADD, $urandom_range(0, n-1),
                              $urandom_range(0, n-1), draw_gap(), 1'b0, '0);
                else
                    send_item(scc_pkg::FUNC_ADD, $urandom_range(0, 63),
                              $urandom_range(0, 63), draw_gap(), 1'b0, '0);
            end
            send_item(scc_pkg::FUNC_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                      draw_gap(), 1'b0, '0);
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Sent %0d transactions (%0d runs), checked %0d node reports.",
                 items_sent, runs_sent, reports_seen);
        $display("Node counts from 0 to saturated, with bad edges, duplicates and stalls.");
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // result side
    initial
    begin
        node_report_t got;
        node_report_t want;
        int hold;
        out_stall  = 1'b1;
        flood_done = 0;
        mismatches = 0;
        reports_seen = 0;
        @(posedge clk);
        forever
        begin
            if (flood_req && !flood_done)
            begin
                hold = 400;
                flood_done = 1;
            end
            else
            begin
                hold = quiet ? 0 : $urandom_range(0, 18);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(negedge clk);
            while (!out_valid);
            got = '{status, node_id, component_index, component_end, run_end};
            @(posedge clk);
            reports_seen++;
            if (pending_reports.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected transaction %p", got));
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.status != want.status)
                    flag_mismatch($sformatf("status %0d want %0d", got.status, want.status));
                if (got.node_id != want.node_id)
                    flag_mismatch($sformatf("node_id %0d want %0d", got.node_id, want.node_id));
                if (got.comp != want.comp)
                    flag_mismatch($sformatf("component_index %0d want %0d",
                                            got.comp, want.comp));
                if (got.comp_end != want.comp_end)
                    flag_mismatch($sformatf("component_end %0b want %0b",
                                            got.comp_end, want.comp_end));
                if (got.last_of_run != want.last_of_run)
                    flag_mismatch($sformatf("run_end %0b want %0b",
                                            got.last_of_run, want.last_of_run));
            end
        end
    end

    // watchdog
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 200000)
            begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("tb_top: errors");
                $finish;
            end
        end
    end

endmodule

// File: scc_condensation_order.f
src/scc_pkg.sv
src/scc_ctrl.sv
src/scc_dpath.sv
src/scc_condensation_order.sv
tb/tb_top.sv
